// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the LCD write sequencer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an active-low reset qualifier.
`define LCDWS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the block clock and reset.
`define LCDWS_ASSERT(lbl, prop, msg) \
    `LCDWS_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)

`endif

// ===== rtl/core/lcdws_pkg.sv =====
// ----------------------------------------------------------------------------
// LCD write sequencer package
// Types, constants and init tables shared by the sequencer modules.
// ----------------------------------------------------------------------------
package lcdws_pkg;

    localparam int POWER_UP_WAIT_US = 150000;
    localparam int CLEAR_WAIT_US    = 3000;
    localparam int PULSE_RESET_US   = 100;
    localparam int INIT_COUNT       = 7;

    localparam int DELAY_W = 18;
    localparam int AFTER_W = 12;
    localparam int GAP_W   = 14;
    localparam int STEP_W  = 3;
    localparam int PULSE_W = 10;
    localparam int OP_W    = 3;

    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_COMMAND = 3'd1;
    localparam logic [OP_W-1:0] OP_DATA    = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd3;
    localparam logic [OP_W-1:0] OP_HOME    = 3'd4;
    localparam logic [OP_W-1:0] OP_SET_POS = 3'd5;

    localparam logic [7:0] CMD_CLEAR = 8'h01;
    localparam logic [7:0] CMD_HOME  = 8'h02;
    localparam logic [7:0] CMD_ENTRY = 8'h06;

    typedef enum logic [7:0] {
        PH_IDLE      = 8'b0000_0001,
        PH_POWERUP   = 8'b0000_0010,
        PH_CMD_HIGH  = 8'b0000_0100,
        PH_CMD_LOW   = 8'b0000_1000,
        PH_POST      = 8'b0001_0000,
        PH_DATA_PRE  = 8'b0010_0000,
        PH_DATA_HIGH = 8'b0100_0000,
        PH_DATA_LOW  = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        phase_t               phase;
        logic [DELAY_W-1:0]   delay_left;
        logic [STEP_W-1:0]    init_step;
        logic [7:0]           cur_byte;
        logic                 cur_rs;
        logic                 entry_pending;
        logic [AFTER_W-1:0]   after_wait;
    } lcdws_state_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [7:0]      value;
        logic [5:0]      column;
        logic            row;
    } lcdws_item_t;

    typedef struct packed {
        logic       rs_line;
        logic       en_line;
        logic [7:0] data_bus;
        logic       busy_res;
        logic       rejected;
    } lcdws_result_t;

    function automatic logic [7:0] init_byte(input logic [STEP_W-1:0] step);
        logic [7:0] b;
        unique case (step)
            3'd0:    b = 8'h08;
            3'd1:    b = 8'h38;
            3'd2:    b = 8'h38;
            3'd3:    b = 8'h38;
            3'd4:    b = 8'h01;
            3'd5:    b = 8'h06;
            default: b = 8'h0C;
        endcase
        return b;
    endfunction

    function automatic logic [GAP_W-1:0] init_gap(input logic [STEP_W-1:0] step);
        logic [GAP_W-1:0] g;
        unique case (step)
            3'd0:    g = GAP_W'(1000);
            3'd1:    g = GAP_W'(100);
            3'd2:    g = GAP_W'(100);
            3'd3:    g = GAP_W'(100);
            3'd4:    g = GAP_W'(100);
            3'd5:    g = GAP_W'(10000);
            default: g = GAP_W'(0);
        endcase
        return g;
    endfunction

endpackage

// ===== rtl/core/lcdws_step.sv =====
// ----------------------------------------------------------------------------
// LCD write sequencer step logic
// Computes the next sequencer state and the pin result for one item.
// ----------------------------------------------------------------------------
module lcdws_step
    import lcdws_pkg::*;
(
    input  lcdws_state_t        state,
    input  lcdws_item_t         item,
    input  logic [PULSE_W-1:0]  pulse_us,
    output lcdws_state_t        state_next,
    output lcdws_result_t       result
);

    logic [DELAY_W-1:0] plen;
    logic [GAP_W-1:0]   gap;
    logic               busy;
    logic               is_tick;
    logic               do_next;
    logic               rej;
    lcdws_state_t       ns;

    assign plen = (pulse_us == '0) ? DELAY_W'(1) : DELAY_W'(pulse_us);
    assign busy = (state.phase != PH_IDLE);

    always_comb begin
        unique case (item.op)
            OP_COMMAND, OP_DATA, OP_CLEAR, OP_HOME, OP_SET_POS: is_tick = 1'b0;
            default:                                            is_tick = 1'b1;
        endcase
    end

    always_comb begin
        ns      = state;
        do_next = 1'b0;
        rej     = 1'b0;
        gap     = '0;
        if (is_tick) begin
            if (busy) begin
                if (state.delay_left <= DELAY_W'(1)) begin
                    unique case (state.phase)
                        PH_POWERUP: begin
                            ns.init_step = '0;
                            do_next = 1'b1;
                        end
                        PH_CMD_HIGH: begin
                            ns.phase = PH_CMD_LOW;
                            ns.delay_left = plen;
                        end
                        PH_CMD_LOW: begin
                            if (state.init_step < STEP_W'(INIT_COUNT)) begin
                                gap = init_gap(state.init_step);
                                ns.init_step = state.init_step + STEP_W'(1);
                            end else begin
                                gap = GAP_W'(state.after_wait);
                                ns.after_wait = '0;
                            end
                            if (gap != '0) begin
                                ns.phase = PH_POST;
                                ns.delay_left = DELAY_W'(gap);
                            end else begin
                                do_next = 1'b1;
                            end
                        end
                        PH_POST: begin
                            do_next = 1'b1;
                        end
                        PH_DATA_PRE: begin
                            ns.cur_rs = 1'b1;
                            ns.phase = PH_DATA_HIGH;
                            ns.delay_left = plen;
                        end
                        PH_DATA_HIGH: begin
                            ns.phase = PH_DATA_LOW;
                            ns.delay_left = plen;
                        end
                        PH_DATA_LOW: begin
                            do_next = 1'b1;
                        end
                        default: begin
                            ns.phase = PH_IDLE;
                            ns.delay_left = '0;
                        end
                    endcase
                    if (do_next) begin
                        if (ns.init_step < STEP_W'(INIT_COUNT)) begin
                            ns.cur_rs = 1'b0;
                            ns.cur_byte = init_byte(ns.init_step);
                            ns.phase = PH_CMD_HIGH;
                            ns.delay_left = plen;
                        end else if (ns.entry_pending) begin
                            ns.entry_pending = 1'b0;
                            ns.after_wait = '0;
                            ns.cur_rs = 1'b0;
                            ns.cur_byte = CMD_ENTRY;
                            ns.phase = PH_CMD_HIGH;
                            ns.delay_left = plen;
                        end else begin
                            ns.phase = PH_IDLE;
                            ns.delay_left = '0;
                        end
                    end
                end else begin
                    ns.delay_left = state.delay_left - DELAY_W'(1);
                end
            end
        end else if (busy) begin
            rej = 1'b1;
        end else begin
            ns.cur_rs = 1'b0;
            ns.phase = PH_CMD_HIGH;
            ns.delay_left = plen;
            ns.after_wait = '0;
            unique case (item.op)
                OP_DATA: begin
                    ns.cur_byte = item.value;
                    ns.entry_pending = 1'b1;
                    ns.phase = PH_DATA_PRE;
                end
                OP_CLEAR: begin
                    ns.after_wait = AFTER_W'(CLEAR_WAIT_US);
                    ns.cur_byte = CMD_CLEAR;
                end
                OP_HOME: begin
                    ns.after_wait = AFTER_W'(CLEAR_WAIT_US);
                    ns.cur_byte = CMD_HOME;
                end
                OP_SET_POS: begin
                    ns.cur_byte = {1'b1, item.row, item.column};
                end
                default: begin
                    ns.cur_byte = item.value;
                end
            endcase
        end
    end

    assign state_next      = ns;
    assign result.rs_line  = ns.cur_rs;
    assign result.en_line  = (ns.phase == PH_CMD_HIGH) || (ns.phase == PH_DATA_HIGH);
    assign result.data_bus = ns.cur_byte;
    assign result.busy_res = (ns.phase != PH_IDLE);
    assign result.rejected = rej;

endmodule

// ===== rtl/core/char_lcd_write_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// Character LCD write sequencer, top level
// Drives an 8-bit character LCD bus from tick and write requests.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the s_ channel is either a one-microsecond tick or a
// request (command, data, clear, home, set position). Every accepted item
// produces exactly one result transfer on the m_ channel with the rs, en and
// data pin levels after that item, a busy flag and a rejected flag.
// A request that arrives while a sequence runs is dropped and flagged.
// An accepted item is held in the input register, which feeds the state
// update, whose result is registered in the result register.
// Throughput is one item per cycle while the receiver is not stalling.
// When the receiver stalls, the result register holds and the input
// register takes one more item; after that s_ready drops until m_ready.
// Reset starts the power-up wait followed by the init command sequence.
// The cfg channel writes pulse_us and is always ready; it is to be written
// only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer_top
    import lcdws_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_op,
    input  logic [7:0]          s_value,
    input  logic [5:0]          s_column,
    input  logic                s_row,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_rs_line,
    output logic                m_en_line,
    output logic [7:0]          m_data_bus,
    output logic                m_busy_res,
    output logic                m_rejected,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [PULSE_W-1:0]  cfg_data
);

    logic               in_valid_reg;
    logic               in_valid_next;
    lcdws_item_t        in_item_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    lcdws_result_t      out_res_reg;
    lcdws_state_t       state_reg;
    lcdws_state_t       state_next;
    lcdws_result_t      step_res;
    logic [PULSE_W-1:0] pulse_reg;
    logic               out_free;
    logic               step_en;

    assign out_free = !out_valid_reg || m_ready;
    assign step_en  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    lcdws_step u_step (
        .state      (state_reg),
        .item       (in_item_reg),
        .pulse_us   (pulse_reg),
        .state_next (state_next),
        .result     (step_res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step_en) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (step_en) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pulse_reg     <= PULSE_W'(PULSE_RESET_US);
            state_reg     <= '{phase:         PH_POWERUP,
                               delay_left:    DELAY_W'(POWER_UP_WAIT_US),
                               init_step:     '0,
                               cur_byte:      '0,
                               cur_rs:        1'b0,
                               entry_pending: 1'b0,
                               after_wait:    '0};
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                pulse_reg <= cfg_data;
            end
            if (step_en) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= '{op: s_op, value: s_value, column: s_column, row: s_row};
        end
        if (step_en) begin
            out_res_reg <= step_res;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_rs_line  = out_res_reg.rs_line;
    assign m_en_line  = out_res_reg.en_line;
    assign m_data_bus = out_res_reg.data_bus;
    assign m_busy_res = out_res_reg.busy_res;
    assign m_rejected = out_res_reg.rejected;

endmodule

// ===== rtl/core/lcdws_checker.sv =====
// ----------------------------------------------------------------------------
// LCD write sequencer checker
// Port-level assertions bound to the sequencer top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcdws_checker
    import lcdws_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic                m_rs_line,
    input logic                m_en_line,
    input logic [7:0]          m_data_bus,
    input logic                m_busy_res,
    input logic                m_rejected
);

    `LCDWS_ASSERT(a_stall_hold, m_valid && !m_ready |=> m_valid && $stable(m_data_bus) && $stable(m_en_line), "Result changed during a stall.")
    `LCDWS_ASSERT(a_en_needs_busy, m_valid && m_en_line |-> m_busy_res, "Enable high while not busy.")
    `LCDWS_ASSERT(a_reject_needs_busy, m_valid && m_rejected |-> m_busy_res, "Rejected transfer while not busy.")
    `LCDWS_ASSERT(a_ready_when_empty, !m_valid |-> s_ready, "Input not ready with empty result register.")

endmodule

bind char_lcd_write_sequencer_top lcdws_checker u_lcdws_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_rs_line  (m_rs_line),
    .m_en_line  (m_en_line),
    .m_data_bus (m_data_bus),
    .m_busy_res (m_busy_res),
    .m_rejected (m_rejected)
);
